>>> hw/rtl/dlx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlx_pkg
// Shared types, codes and DEFLATE base tables for the LZ77 symbol expander.
// ----------------------------------------------------------------------------
package dlx_pkg;

  localparam int MAX_LANE       = 8;
  localparam int SYM_EOB        = 256;
  localparam int SYM_LEN_FIRST  = 257;
  localparam int SYM_LEN_END    = 286;
  localparam int DIST_CODES     = 30;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_SYM  = 2'd1,
    ERR_BAD_DIST = 2'd2,
    ERR_TOO_FAR  = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    KIND_LIT,
    KIND_EOB,
    KIND_BAD,
    KIND_MATCH
  } sym_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_WRITE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic copy_start;
    logic emit_err;
    logic rd;
    logic wr;
    logic emit_word;
  } dlx_cmd_t;

  typedef struct packed {
    sym_kind_t kind;
    logic      check_fail;
    logic      fill_stop;
    logic      remaining_zero;
    logic      out_free;
  } dlx_stat_t;

  function automatic logic [8:0] len_start_lut(input logic [4:0] idx);
    logic [8:0] r;
    unique case (idx)
      5'd0:    r = 9'd3;
      5'd1:    r = 9'd4;
      5'd2:    r = 9'd5;
      5'd3:    r = 9'd6;
      5'd4:    r = 9'd7;
      5'd5:    r = 9'd8;
      5'd6:    r = 9'd9;
      5'd7:    r = 9'd10;
      5'd8:    r = 9'd11;
      5'd9:    r = 9'd13;
      5'd10:   r = 9'd15;
      5'd11:   r = 9'd17;
      5'd12:   r = 9'd19;
      5'd13:   r = 9'd23;
      5'd14:   r = 9'd27;
      5'd15:   r = 9'd31;
      5'd16:   r = 9'd35;
      5'd17:   r = 9'd43;
      5'd18:   r = 9'd51;
      5'd19:   r = 9'd59;
      5'd20:   r = 9'd67;
      5'd21:   r = 9'd83;
      5'd22:   r = 9'd99;
      5'd23:   r = 9'd115;
      5'd24:   r = 9'd131;
      5'd25:   r = 9'd163;
      5'd26:   r = 9'd195;
      5'd27:   r = 9'd227;
      5'd28:   r = 9'd258;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] len_bits(input logic [4:0] idx);
    logic [2:0] r;
    if (idx >= 5'd28) begin
      r = 3'd0;
    end else if (idx < 5'd8) begin
      r = 3'd0;
    end else begin
      r = 3'(idx[4:2] - 3'd1);
    end
    return r;
  endfunction

  function automatic logic [15:0] dist_start_lut(input logic [4:0] code);
    logic [15:0] r;
    unique case (code)
      5'd0:    r = 16'd1;
      5'd1:    r = 16'd2;
      5'd2:    r = 16'd3;
      5'd3:    r = 16'd4;
      5'd4:    r = 16'd5;
      5'd5:    r = 16'd7;
      5'd6:    r = 16'd9;
      5'd7:    r = 16'd13;
      5'd8:    r = 16'd17;
      5'd9:    r = 16'd25;
      5'd10:   r = 16'd33;
      5'd11:   r = 16'd49;
      5'd12:   r = 16'd65;
      5'd13:   r = 16'd97;
      5'd14:   r = 16'd129;
      5'd15:   r = 16'd193;
      5'd16:   r = 16'd257;
      5'd17:   r = 16'd385;
      5'd18:   r = 16'd513;
      5'd19:   r = 16'd769;
      5'd20:   r = 16'd1025;
      5'd21:   r = 16'd1537;
      5'd22:   r = 16'd2049;
      5'd23:   r = 16'd3073;
      5'd24:   r = 16'd4097;
      5'd25:   r = 16'd6145;
      5'd26:   r = 16'd8193;
      5'd27:   r = 16'd12289;
      5'd28:   r = 16'd16385;
      5'd29:   r = 16'd24577;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] dist_bits(input logic [4:0] code);
    logic [3:0] r;
    if (code < 5'd4 || code >= 5'd30) begin
      r = 4'd0;
    end else begin
      r = 4'(code[4:1] - 4'd1);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/dlx_sym_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlx_sym_if
// Symbol channel: one decoded literal/length symbol with its extra fields.
// ----------------------------------------------------------------------------
interface dlx_sym_if;
  logic        valid;
  logic        ready;
  logic [8:0]  lit_len_symbol;
  logic [4:0]  length_extra;
  logic [4:0]  distance_code;
  logic [12:0] distance_extra;

  modport source (
    output valid, lit_len_symbol, length_extra, distance_code, distance_extra,
    input  ready
  );
  modport sink (
    input  valid, lit_len_symbol, length_extra, distance_code, distance_extra,
    output ready
  );
endinterface

>>> hw/rtl/dlx_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlx_res_if
// Result channel: up to eight output bytes with count, run and status flags.
// ----------------------------------------------------------------------------
interface dlx_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic        end_of_block;
  logic [1:0]  error_code;

  modport source (
    output valid, out_bytes, byte_count, last_of_run, end_of_block, error_code,
    input  ready
  );
  modport sink (
    input  valid, out_bytes, byte_count, last_of_run, end_of_block, error_code,
    output ready
  );
endinterface

>>> hw/rtl/deflate_lz77_symbol_expander_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deflate_lz77_symbol_expander_unit
// DEFLATE LZ77 expander: literals, end of block and back-reference copies
// through a history window, packed up to eight bytes per result.
//
//   channel | direction | transfer carries
//   --------+-----------+----------------------------------------------------
//   sym     | in        | lit_len_symbol, length_extra, distance_code/extra
//   res     | out       | out_bytes, byte_count, last_of_run, end_of_block,
//           |           | error_code
//
// Literal, end of block and bad symbol: result registered on acceptance.
// Match: decode on acceptance and check in the check state, then each copied
// byte is read and then written back on the history RAM, and each result
// word of up to eight bytes goes out in the emit step.
// Synchronous reset clears the write pointer and fill count; the RAM is not cleared.
// A stalled result holds its register and the copy waits at the emit step.
// ----------------------------------------------------------------------------
module deflate_lz77_symbol_expander_unit #(
  parameter int WINDOW_BYTES = 32768,
  parameter int LANE_BYTES   = 8
) (
  input logic      clk,
  input logic      rst,
  dlx_sym_if.sink  sym,
  dlx_res_if.source res
);
  import dlx_pkg::*;

  dlx_cmd_t  cmd;
  dlx_stat_t stat;

  dlx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sym.valid),
    .in_ready (sym.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dlx_datapath #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .LANE_BYTES   (LANE_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .lit_len_symbol (sym.lit_len_symbol),
    .length_extra   (sym.length_extra),
    .distance_code  (sym.distance_code),
    .distance_extra (sym.distance_extra),
    .out_valid      (res.valid),
    .out_ready      (res.ready),
    .out_bytes      (res.out_bytes),
    .byte_count     (res.byte_count),
    .last_of_run    (res.last_of_run),
    .end_of_block   (res.end_of_block),
    .error_code     (res.error_code)
  );

endmodule

>>> hw/rtl/dlx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlx_ctrl
// Controller: sequences symbol intake, match check, byte copy and result emit.
// ----------------------------------------------------------------------------
module dlx_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dlx_pkg::dlx_stat_t stat,
  output dlx_pkg::dlx_cmd_t  cmd
);
  import dlx_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.accept = 1'b1;
          if (stat.kind == KIND_MATCH) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.check_fail) begin
          if (stat.out_free) begin
            cmd.emit_err = 1'b1;
            state_next   = ST_IDLE;
          end
        end else begin
          cmd.copy_start = 1'b1;
          state_next     = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr     = 1'b1;
        state_next = stat.fill_stop ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_word = 1'b1;
          state_next    = stat.remaining_zero ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/dlx_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlx_datapath
// Datapath: history RAM, pointers, length/distance decode, word packing and
// the result register.
// ----------------------------------------------------------------------------
module dlx_datapath #(
  parameter int WINDOW_BYTES = 32768,
  parameter int LANE_BYTES   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  dlx_pkg::dlx_cmd_t  cmd,
  output dlx_pkg::dlx_stat_t stat,
  input  logic [8:0]         lit_len_symbol,
  input  logic [4:0]         length_extra,
  input  logic [4:0]         distance_code,
  input  logic [12:0]        distance_extra,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_bytes,
  output logic [3:0]         byte_count,
  output logic               last_of_run,
  output logic               end_of_block,
  output logic [1:0]         error_code
);
  import dlx_pkg::*;

  localparam int AW       = $clog2(WINDOW_BYTES);
  localparam int FW       = $clog2(WINDOW_BYTES + 1);
  localparam int EFF_LANE = (LANE_BYTES > MAX_LANE) ? MAX_LANE : LANE_BYTES;

  logic [7:0]    mem [WINDOW_BYTES];
  logic [AW-1:0] wp;
  logic [AW-1:0] wp_next;
  logic [FW-1:0] filled;
  logic [FW-1:0] filled_next;
  logic [AW-1:0] src;
  logic [AW-1:0] src_inc;
  logic [7:0]    rdata;
  logic [8:0]    remaining;
  logic [15:0]   match_dist;
  logic          dcode_bad;
  logic [63:0]   word;
  logic [3:0]    n;

  sym_kind_t     kind;
  logic [8:0]    len_idx;
  logic [4:0]    len_mask;
  logic [12:0]   dist_mask;
  logic [8:0]    len_calc;
  logic [15:0]   dist_calc;
  logic [16:0]   src_calc;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          out_free;
  logic          out_load;

  always_comb begin
    if (lit_len_symbol < 9'(SYM_EOB)) begin
      kind = KIND_LIT;
    end else if (lit_len_symbol == 9'(SYM_EOB)) begin
      kind = KIND_EOB;
    end else if (lit_len_symbol >= 9'(SYM_LEN_END)) begin
      kind = KIND_BAD;
    end else begin
      kind = KIND_MATCH;
    end
  end

  assign len_idx   = 9'(lit_len_symbol - 9'(SYM_LEN_FIRST));
  assign len_mask  = 5'((6'd1 << len_bits(len_idx[4:0])) - 6'd1);
  assign dist_mask = 13'((14'd1 << dist_bits(distance_code)) - 14'd1);
  assign len_calc  = len_start_lut(len_idx[4:0]) + 9'(length_extra & len_mask);
  assign dist_calc = dist_start_lut(distance_code) + 16'(distance_extra & dist_mask);

  always_comb begin
    if (17'(wp) >= 17'(match_dist)) begin
      src_calc = 17'(wp) - 17'(match_dist);
    end else begin
      src_calc = 17'(wp) + 17'(WINDOW_BYTES) - 17'(match_dist);
    end
  end

  assign wp_next     = (wp == AW'(WINDOW_BYTES - 1)) ? '0 : wp + 1'b1;
  assign src_inc     = (src == AW'(WINDOW_BYTES - 1)) ? '0 : src + 1'b1;
  assign filled_next = (filled == FW'(WINDOW_BYTES)) ? filled : filled + 1'b1;

  assign out_free  = !out_valid || out_ready;
  assign mem_we    = (cmd.accept && kind == KIND_LIT) || cmd.wr;
  assign mem_wdata = cmd.wr ? rdata : lit_len_symbol[7:0];
  assign out_load  = (cmd.accept && kind != KIND_MATCH) || cmd.emit_err || cmd.emit_word;

  assign stat.kind           = kind;
  assign stat.check_fail     = dcode_bad || (match_dist > 16'(filled));
  assign stat.fill_stop      = (remaining == 9'd1) || (n == 4'(EFF_LANE - 1));
  assign stat.remaining_zero = (remaining == 9'd0);
  assign stat.out_free       = out_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= mem_wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      filled <= '0;
    end else if (mem_we) begin
      wp     <= wp_next;
      filled <= filled_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      remaining  <= len_calc;
      match_dist <= dist_calc;
      dcode_bad  <= (distance_code >= 5'(DIST_CODES));
    end
    if (cmd.copy_start) begin
      src  <= src_calc[AW-1:0];
      word <= '0;
      n    <= '0;
    end
    if (cmd.rd) begin
      src <= src_inc;
    end
    if (cmd.wr) begin
      word[8*n[2:0] +: 8] <= rdata;
      n                   <= n + 4'd1;
      remaining           <= remaining - 9'd1;
    end
    if (cmd.emit_word) begin
      word <= '0;
      n    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd.emit_word) begin
        out_bytes    <= word;
        byte_count   <= n;
        last_of_run  <= (remaining == 9'd0);
        end_of_block <= 1'b0;
        error_code   <= ERR_NONE;
      end else if (cmd.emit_err) begin
        out_bytes    <= '0;
        byte_count   <= '0;
        last_of_run  <= 1'b1;
        end_of_block <= 1'b0;
        error_code   <= dcode_bad ? ERR_BAD_DIST : ERR_TOO_FAR;
      end else begin
        out_bytes    <= (kind == KIND_LIT) ? 64'(lit_len_symbol[7:0]) : 64'd0;
        byte_count   <= (kind == KIND_LIT) ? 4'd1 : 4'd0;
        last_of_run  <= 1'b1;
        end_of_block <= (kind == KIND_EOB);
        error_code   <= (kind == KIND_BAD) ? ERR_BAD_SYM : ERR_NONE;
      end
    end
  end

endmodule

>>> hw/rtl/dlx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlx_checker
// Port-level checks on the result channel of the LZ77 expander.
// ----------------------------------------------------------------------------
module dlx_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bytes,
  input logic [3:0]  byte_count,
  input logic        last_of_run,
  input logic        end_of_block,
  input logic [1:0]  error_code
);
  import dlx_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes) &&
      $stable(byte_count) && $stable(last_of_run) && $stable(error_code))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_count <= 4'(MAX_LANE))
    else $error("byte count above lane width");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |->
      byte_count == 4'd0 && last_of_run && !end_of_block && out_bytes == 64'd0)
    else $error("error result carries data");

  a_eob: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_block |->
      byte_count == 4'd0 && last_of_run && error_code == ERR_NONE)
    else $error("malformed end of block");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_count == 4'd0 |-> end_of_block || error_code != ERR_NONE)
    else $error("empty result without cause");

endmodule

bind deflate_lz77_symbol_expander_unit dlx_checker u_dlx_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .out_bytes    (res.out_bytes),
  .byte_count   (res.byte_count),
  .last_of_run  (res.last_of_run),
  .end_of_block (res.end_of_block),
  .error_code   (res.error_code)
);
